@@ rtl/hpt_pkg.sv @@
// shared widths, types and the divider step for the homography point transform
package hpt_pkg;

   localparam int COORD_WIDTH    = 16;
   localparam int COEF_FRAC_BITS = 20;
   localparam int OUT_FRAC_BITS  = 16;
   localparam int COEF_W         = 32;
   localparam int CSR_W          = 64;
   localparam int CSR_IDX_W      = 3;
   localparam int OUT_W          = 32;
   localparam int PROD_W         = COEF_W + COORD_WIDTH;
   localparam int SUM_W          = PROD_W + 2;
   localparam int NUM_W          = SUM_W + OUT_FRAC_BITS;
   localparam int Q_W            = OUT_W;
   localparam int DSH_W          = SUM_W + Q_W;
   localparam int DIV_STEPS      = Q_W;

   localparam logic [Q_W-1:0] LIM_POS = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic [Q_W-1:0] LIM_NEG = {1'b1, {(Q_W-1){1'b0}}};
   localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << COEF_FRAC_BITS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_M00_M01 = 3'd0,
      CSR_M02_M10 = 3'd1,
      CSR_M11_M12 = 3'd2,
      CSR_M20_M21 = 3'd3,
      CSR_M22     = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [SUM_W-1:0] rem;
      logic [Q_W-1:0]   quo;
   } hpt_part_type;

   typedef struct packed {
      logic             zero;
      logic             neg_x;
      logic             neg_y;
      logic             ovf_x;
      logic             ovf_y;
      logic [SUM_W-1:0] den;
      hpt_part_type     px;
      hpt_part_type     py;
   } hpt_div_type;

   function automatic hpt_part_type hpt_div_step(hpt_part_type cur, logic [SUM_W-1:0] den);
      logic [SUM_W:0] trial;
      hpt_part_type   nxt;
      trial = {cur.rem, cur.quo[Q_W-1]};
      if (trial >= {1'b0, den}) begin
         nxt.rem = SUM_W'(trial - {1'b0, den});
         nxt.quo = {cur.quo[Q_W-2:0], 1'b1};
      end else begin
         nxt.rem = trial[SUM_W-1:0];
         nxt.quo = {cur.quo[Q_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

@@ rtl/homography_point_transform_top.sv @@
// homography point transform: products, sums, setup, bit-serial pipelined dividers, clamp
//
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_src_x, req_src_y
// rsp     | out       | rsp_valid/rsp_ready  | rsp_dst_x, rsp_dst_y, rsp_denom_zero, rsp_saturated
// csr     | in        | csr_write_en         | csr_index, csr_data
//
// one item per cycle unless a waiting result stalls the pipeline; stages: input, product, sum, setup, 32 divider
// stages (one quotient bit each, set by the restoring divider chain) and output
// reset clears the valid bits and loads the identity map
// the whole pipeline holds while a result waits on rsp_ready
module homography_point_transform_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [hpt_pkg::COORD_WIDTH-1:0] req_src_x,
   input  logic signed [hpt_pkg::COORD_WIDTH-1:0] req_src_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [hpt_pkg::OUT_W-1:0]     rsp_dst_x,
   output logic signed [hpt_pkg::OUT_W-1:0]     rsp_dst_y,
   output logic                                 rsp_denom_zero,
   output logic                                 rsp_saturated,
   input  logic                                 csr_write_en,
   input  logic [hpt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hpt_pkg::CSR_W-1:0]            csr_data
);
   import hpt_pkg::*;

   logic [CSR_W-1:0]  coef0_ff, coef1_ff, coef2_ff, coef3_ff;
   logic [COEF_W-1:0] coef4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef0_ff <= CSR_W'(COEF_ONE);
         coef1_ff <= '0;
         coef2_ff <= CSR_W'(COEF_ONE);
         coef3_ff <= '0;
         coef4_ff <= COEF_ONE;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_M00_M01: coef0_ff <= csr_data;
            CSR_M02_M10: coef1_ff <= csr_data;
            CSR_M11_M12: coef2_ff <= csr_data;
            CSR_M20_M21: coef3_ff <= csr_data;
            CSR_M22:     coef4_ff <= csr_data[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   logic signed [COEF_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
   assign m00 = $signed(coef0_ff[COEF_W-1:0]);
   assign m01 = $signed(coef0_ff[CSR_W-1:COEF_W]);
   assign m02 = $signed(coef1_ff[COEF_W-1:0]);
   assign m10 = $signed(coef1_ff[CSR_W-1:COEF_W]);
   assign m11 = $signed(coef2_ff[COEF_W-1:0]);
   assign m12 = $signed(coef2_ff[CSR_W-1:COEF_W]);
   assign m20 = $signed(coef3_ff[COEF_W-1:0]);
   assign m21 = $signed(coef3_ff[CSR_W-1:COEF_W]);
   assign m22 = $signed(coef4_ff);

   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // input stage
   logic                          v1_ff;
   logic signed [COORD_WIDTH-1:0] x1_ff, y1_ff;
   // product stage
   logic                     v2_ff;
   logic signed [PROD_W-1:0] p00_ff, p01_ff, p10_ff, p11_ff, p20_ff, p21_ff;
   // sum stage
   logic                    v3_ff;
   logic signed [SUM_W-1:0] u3_ff, v3s_ff, w3_ff;
   // divider chain
   logic        dv_ff [DIV_STEPS+1];
   hpt_div_type ds_ff [DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff  <= req_src_x;
         y1_ff  <= req_src_y;
         p00_ff <= m00 * x1_ff;
         p01_ff <= m01 * y1_ff;
         p10_ff <= m10 * x1_ff;
         p11_ff <= m11 * y1_ff;
         p20_ff <= m20 * x1_ff;
         p21_ff <= m21 * y1_ff;
         u3_ff  <= SUM_W'(p00_ff) + SUM_W'(p01_ff) + SUM_W'(m02);
         v3s_ff <= SUM_W'(p10_ff) + SUM_W'(p11_ff) + SUM_W'(m12);
         w3_ff  <= SUM_W'(p20_ff) + SUM_W'(p21_ff) + SUM_W'(m22);
      end
   end

   // setup: magnitudes, signs, overflow test and first remainder
   logic [SUM_W-1:0] au, av, aw;
   logic [NUM_W-1:0] nu, nv;
   logic [DSH_W-1:0] dshift;
   hpt_div_type      setup;
   always_comb begin
      au = u3_ff[SUM_W-1]  ? SUM_W'(-u3_ff)  : u3_ff;
      av = v3s_ff[SUM_W-1] ? SUM_W'(-v3s_ff) : v3s_ff;
      aw = w3_ff[SUM_W-1]  ? SUM_W'(-w3_ff)  : w3_ff;
      nu = {au, {OUT_FRAC_BITS{1'b0}}};
      nv = {av, {OUT_FRAC_BITS{1'b0}}};
      dshift = {aw, {Q_W{1'b0}}};
      setup.zero   = (w3_ff == '0);
      setup.neg_x  = u3_ff[SUM_W-1] ^ w3_ff[SUM_W-1];
      setup.neg_y  = v3s_ff[SUM_W-1] ^ w3_ff[SUM_W-1];
      setup.ovf_x  = DSH_W'(nu) >= dshift;
      setup.ovf_y  = DSH_W'(nv) >= dshift;
      setup.den    = aw;
      setup.px.rem = SUM_W'(nu >> Q_W);
      setup.px.quo = nu[Q_W-1:0];
      setup.py.rem = SUM_W'(nv >> Q_W);
      setup.py.quo = nv[Q_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ds_ff[0] <= setup;
      end
   end

   for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_div
      hpt_div_type step_in;
      always_comb begin
         step_in    = ds_ff[s-1];
         step_in.px = hpt_div_step(ds_ff[s-1].px, ds_ff[s-1].den);
         step_in.py = hpt_div_step(ds_ff[s-1].py, ds_ff[s-1].den);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[s] <= 1'b0;
         end else if (adv) begin
            dv_ff[s] <= dv_ff[s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            ds_ff[s] <= step_in;
         end
      end
   end

   // clamp and sign
   hpt_div_type      fin;
   logic [Q_W-1:0]   lim_x, lim_y, mag_x, mag_y;
   logic             sat_x, sat_y;
   logic             rsp_valid_ff, rsp_zero_ff, rsp_sat_ff;
   logic [OUT_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [OUT_W-1:0] dst_x_in, dst_y_in;
   logic             sat_in;
   always_comb begin
      fin   = ds_ff[DIV_STEPS];
      lim_x = fin.neg_x ? LIM_NEG : LIM_POS;
      lim_y = fin.neg_y ? LIM_NEG : LIM_POS;
      sat_x = fin.ovf_x || (fin.px.quo > lim_x);
      sat_y = fin.ovf_y || (fin.py.quo > lim_y);
      mag_x = sat_x ? lim_x : fin.px.quo;
      mag_y = sat_y ? lim_y : fin.py.quo;
      if (fin.zero) begin
         dst_x_in = '0;
         dst_y_in = '0;
         sat_in   = 1'b0;
      end else begin
         dst_x_in = fin.neg_x ? (~mag_x + 1'b1) : mag_x;
         dst_y_in = fin.neg_y ? (~mag_y + 1'b1) : mag_y;
         sat_in   = sat_x || sat_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_x_ff    <= dst_x_in;
         rsp_y_ff    <= dst_y_in;
         rsp_zero_ff <= fin.zero;
         rsp_sat_ff  <= sat_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dst_x      = $signed(rsp_x_ff);
   assign rsp_dst_y      = $signed(rsp_y_ff);
   assign rsp_denom_zero = rsp_zero_ff;
   assign rsp_saturated  = rsp_sat_ff;

`ifndef SYNTHESIS
   a_zero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_denom_zero |-> rsp_dst_x == 0 && rsp_dst_y == 0 && !rsp_saturated)
      else $error("zero denominator result not cleared");
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_dst_x == LIM_POS || rsp_dst_x == LIM_NEG
         || rsp_dst_y == LIM_POS || rsp_dst_y == LIM_NEG)
      else $error("saturated flag without clamped value");
   a_stall_only: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("pipeline stalled without a waiting result");
`endif

endmodule
